// ===== src/srmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package srmc_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned DivWidth = 36;

  localparam logic [CfgIdxWidth-1:0] REG_BACKLASH = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_ACCEL    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MIN_DLY  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_DLY  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_DIR_DLY  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_FULL_CAL = 3'd5;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;

  localparam logic [2:0] PH_BG   = 3'd0;
  localparam logic [2:0] PH_LOW  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT = 3'd3;
  localparam logic [2:0] PH_DIR  = 3'd4;

  localparam logic [1:0] MS_IDLE = 2'd0;
  localparam logic [1:0] MS_UP   = 2'd1;
  localparam logic [1:0] MS_RUN  = 2'd2;
  localparam logic [1:0] MS_DOWN = 2'd3;

  localparam logic [1:0] HS_UNHOMED = 2'd0;
  localparam logic [1:0] HS_HOMING  = 2'd1;
  localparam logic [1:0] HS_BACKOFF = 2'd2;
  localparam logic [1:0] HS_HOMED   = 2'd3;

  localparam logic [15:0] BG_PERIOD = 16'd5000;
  localparam logic [20:0] IDLE_LIMIT = 21'd1000000;
  localparam logic [20:0] IDLE_INC = 21'd5000;
  localparam logic [19:0] ONE_MILLION = 20'd1000000;
  localparam logic [31:0] HOME_RUN_STEPS = 32'd20000;
  localparam logic [31:0] HOME_BACK_STEPS = 32'd2000;
  localparam logic [15:0] PULSE_US = 16'd4;
  localparam logic [15:0] RECALL_US = 16'd2;

  typedef struct packed {
    logic [15:0] backlash_steps;
    logic [15:0] accel_steps;
    logic [15:0] min_delay_us;
    logic [15:0] max_delay_us;
    logic [15:0] dir_settle_us;
    logic        hold_slow;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        cmd_direction;
    logic [15:0] cmd_steps;
    logic        limit_stuck;
    logic        limit_hit;
  } cmd_t;

  typedef struct packed {
    logic        step_pin;
    logic        dir_pin;
    logic        driver_enable;
    logic [15:0] timer_period;
    logic        homed;
    logic        fault;
    logic        motion_started;
    logic        motion_stopped;
    logic        backoff_started;
    logic        position_reset;
    logic [15:0] steps_left;
  } res_t;

  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivWidth-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/srmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface srmc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/srmc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srmc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire srmc_pkg::div_req_t req,
  output srmc_pkg::div_rsp_t      rsp
);
  import srmc_pkg::*;

  logic [DivWidth-1:0] quo;
  logic [DivWidth-1:0] rem;
  logic [DivWidth-1:0] dvs;
  logic [5:0]          cnt;
  logic                busy;
  logic                done_q;
  logic [DivWidth:0]   trial;

  assign trial = {rem, quo[DivWidth-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'(DivWidth);
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (!trial[DivWidth]) begin
          rem <= trial[DivWidth-1:0];
          quo <= {quo[DivWidth-2:0], 1'b1};
        end else begin
          rem <= {rem[DivWidth-2:0], quo[DivWidth-1]};
          quo <= {quo[DivWidth-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_q, quotient: quo};

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(req.start)) else $error("busy without start");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 6'd0) else $error("busy with zero count");
`endif
endmodule
`default_nettype wire

// ===== src/stepper_ramp_motion_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  payload
// cmd      in   op, cmd_direction, cmd_steps, limit_stuck, limit_hit
// res      out  pins, timer_period, status, pulses, steps_left
// cfg      in   cfg_we, cfg_idx, cfg_data (plain write)
// Items that launch a step from a movement decision run four passes of
// the shared 36-bit restoring divider plus a multiply step; other items
// do not use the divider.
// Synchronous active-high reset; one item in flight at a time.
// The result register holds until taken; no new word is taken before that.
module stepper_ramp_motion_controller_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  srmc_if.sink      cmd,
  srmc_if.source    res,
  input  wire logic cfg_we,
  input  wire logic [srmc_pkg::CfgIdxWidth-1:0] cfg_idx,
  input  wire logic [srmc_pkg::CfgWidth-1:0] cfg_data
);
  import srmc_pkg::*;

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV_FLO, S_DIV_FHI, S_DIV_MUL, S_DIV_DLY, S_DONE
  } st_t;

  st_t st;
  cfg_t cfg;
  cmd_t c;
  res_t r;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [2:0]  pulse_phase;
  logic [1:0]  motion_state, home_st, cur_dir, pend_dir;
  logic [COUNT_WIDTH-1:0] rem_steps, pend_steps;
  logic [7:0]  act_ver, pend_ver;
  logic [15:0] ramp_pos, next_dly, backlash_left, period;
  logic [20:0] idle_us;
  logic        en_flag, fault_flag, step_lvl, dir_lvl, dir_target;
  logic        p_start, p_stop, p_back, p_pos;
  logic [19:0] flo, fhi;
  logic [DivWidth-1:0] prod;
  logic [15:0] didx;
  logic        div_go, div_go_next;
  logic [DivWidth-1:0] div_num, div_den;
  logic        res_hold;

  logic [15:0] acc, mind, maxd;
  assign acc  = (cfg.accel_steps == 16'd0) ? 16'd1 : cfg.accel_steps;
  assign mind = (cfg.min_delay_us == 16'd0) ? 16'd1 : cfg.min_delay_us;
  assign maxd = (cfg.max_delay_us == 16'd0) ? 16'd1 : cfg.max_delay_us;

  assign dreq = '{start: div_go, dividend: div_num, divisor: div_den};

  srmc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [COUNT_WIDTH-1:0] sat(input logic [31:0] v);
    sat = (v > CountMax) ? CountMax[COUNT_WIDTH-1:0] : v[COUNT_WIDTH-1:0];
  endfunction

  assign res_hold  = (st == S_DONE) && (didx == 16'hFFFF);
  assign cmd.ready = (st == S_IDLE);
  assign res.valid = (st == S_DONE) && !res_hold;
  assign res.data  = r;

  // decision logic, combinational over the held state
  logic [2:0]  n_ph;
  logic [1:0]  n_ms, n_hs, n_cur, n_pdir;
  logic [COUNT_WIDTH-1:0] n_rem, n_pst;
  logic [7:0]  n_av, n_pv;
  logic [15:0] n_ramp, n_nd, n_bl, n_per;
  logic [20:0] n_idle;
  logic        n_en, n_fault, n_step, n_dirl, n_dt;
  logic        n_ps, n_pp, n_pb, n_pr;
  logic        n_need_div;
  logic [15:0] n_didx;

  always_comb begin
    logic do_dec, launch_max, stop_dec;
    logic [1:0] was;
    logic [31:0] r32, ram32;
    n_ph = pulse_phase; n_ms = motion_state; n_hs = home_st;
    n_cur = cur_dir; n_pdir = pend_dir; n_rem = rem_steps; n_pst = pend_steps;
    n_av = act_ver; n_pv = pend_ver; n_ramp = ramp_pos; n_nd = next_dly;
    n_bl = backlash_left; n_per = period; n_idle = idle_us; n_en = en_flag;
    n_fault = fault_flag; n_step = step_lvl; n_dirl = dir_lvl; n_dt = dir_target;
    n_ps = 1'b0; n_pp = 1'b0; n_pb = 1'b0; n_pr = 1'b0;
    n_need_div = 1'b0; n_didx = ramp_pos;
    do_dec = 1'b0; launch_max = 1'b0; stop_dec = 1'b0; was = MS_IDLE;
    r32 = '0; ram32 = '0;
    if (!fault_flag) begin
      unique case (c.op)
        OP_MOVE: begin
          n_pdir = {1'b0, c.cmd_direction};
          n_pst = sat({16'd0, c.cmd_steps});
          n_pv = pend_ver + 8'd1;
        end
        OP_HOME: n_hs = HS_UNHOMED;
        OP_TICK: begin
          unique case (pulse_phase)
            PH_HIGH: begin n_step = 1'b1; n_ph = PH_LOW; n_per = PULSE_US; end
            PH_LOW: begin n_step = 1'b0; n_ph = PH_WAIT; n_per = next_dly; end
            PH_WAIT: begin
              n_ph = PH_BG;
              if (backlash_left != 16'd0) begin
                n_bl = backlash_left - 16'd1;
                launch_max = 1'b1;
              end else if (home_st == HS_HOMED && c.limit_hit) begin
                n_pp = 1'b1; n_ms = MS_IDLE; n_rem = '0; n_pst = '0;
                n_ramp = 16'd1; n_per = BG_PERIOD;
              end else begin
                if (rem_steps != '0) n_rem = rem_steps - COUNT_WIDTH'(1);
                do_dec = 1'b1;
              end
            end
            PH_DIR: begin
              n_ph = PH_BG; n_dirl = dir_target; n_bl = cfg.backlash_steps;
              if (cfg.backlash_steps != 16'd0) launch_max = 1'b1;
              else do_dec = 1'b1;
            end
            default: begin n_ph = PH_BG; do_dec = 1'b1; end
          endcase
        end
        default: ;
      endcase
    end
    if (launch_max) begin
      n_nd = maxd; n_ph = PH_HIGH; n_per = PULSE_US;
    end
    if (do_dec) begin
      unique case (n_hs)
        HS_UNHOMED: begin
          n_pdir = 2'd0; n_pst = sat(HOME_RUN_STEPS); n_pv = n_pv + 8'd1;
          n_hs = HS_HOMING;
        end
        HS_HOMING: begin
          if (c.limit_stuck) begin
            n_pp = 1'b1; n_ms = MS_IDLE; n_rem = '0; n_ramp = 16'd1;
            n_per = BG_PERIOD; n_pb = 1'b1;
            n_pdir = 2'd1; n_pst = sat(HOME_BACK_STEPS); n_pv = n_pv + 8'd1;
            n_hs = HS_BACKOFF;
          end else if (n_pst == '0) begin
            n_fault = 1'b1; stop_dec = 1'b1;
          end
        end
        HS_BACKOFF: begin
          if (!c.limit_stuck) begin
            n_pr = 1'b1; n_hs = HS_HOMED;
            n_pp = 1'b1; n_ms = MS_IDLE; n_rem = '0; n_pst = '0; n_ramp = 16'd1;
            n_per = BG_PERIOD;
          end else if (n_pst == '0) begin
            n_fault = 1'b1; stop_dec = 1'b1;
          end
        end
        default: if (c.limit_stuck) begin n_fault = 1'b1; stop_dec = 1'b1; end
      endcase
      if (!stop_dec) begin
        if (n_rem == '0 && n_pst == '0) begin
          n_per = BG_PERIOD;
          if (n_idle <= IDLE_LIMIT) n_idle = n_idle + IDLE_INC;
          if (n_idle > IDLE_LIMIT) n_en = 1'b0;
        end else begin
          n_idle = '0;
          was = n_ms;
          unique case (was)
            MS_IDLE: begin
              n_en = 1'b1; n_rem = n_pst; n_av = n_pv; n_ramp = 16'd1;
              if (n_pdir != n_cur) begin
                n_cur = n_pdir; n_dt = n_pdir[0]; n_ph = PH_DIR;
                n_per = cfg.dir_settle_us; stop_dec = 1'b1;
              end else begin
                n_ps = 1'b1;
                r32 = 32'(n_rem);
                n_ms = (r32 <= 32'd1) ? MS_DOWN : MS_UP;
              end
            end
            MS_UP, MS_RUN: begin
              if (n_pv != n_av) begin
                if (n_cur != n_pdir) begin
                  n_ms = MS_IDLE; n_rem = '0; n_ramp = 16'd1;
                end else begin
                  n_rem = n_pst; n_av = n_pv;
                end
              end
              r32 = 32'(n_rem); ram32 = {16'd0, n_ramp};
              if (r32 <= ram32) n_ms = MS_DOWN;
              else if (was == MS_UP && n_ramp >= acc) n_ms = MS_RUN;
            end
            default: begin
              if (n_rem == '0) begin
                n_pp = 1'b1; n_ms = MS_IDLE; stop_dec = 1'b1;
                if (n_av != n_pv) n_per = RECALL_US;
                else begin n_pst = '0; n_ramp = 16'd1; n_per = BG_PERIOD; end
              end
            end
          endcase
          if (!stop_dec) begin
            n_didx = (n_ramp > acc) ? acc : n_ramp;
            n_need_div = 1'b1;
            if (n_ms == MS_UP && n_ramp < acc) begin
              if (!cfg.hold_slow) n_ramp = n_ramp + 16'd1;
            end else if (n_ms == MS_DOWN && n_ramp > 16'd1) begin
              n_ramp = n_ramp - 16'd1;
            end
            n_ph = PH_HIGH; n_per = PULSE_US;
          end
        end
      end
    end
    if (n_fault) begin n_ps = 1'b0; n_pp = 1'b0; n_pb = 1'b0; n_pr = 1'b0; end
  end

  // f = flo + idx*(fhi-flo)/acc, sign handled by magnitude
  logic        neg;
  logic [19:0] fdiff;
  logic [19:0] fval;
  logic [DivWidth-1:0] fq;
  assign neg   = fhi < flo;
  assign fdiff = neg ? (flo - fhi) : (fhi - flo);
  assign fq    = drsp.quotient;
  always_comb begin
    logic [20:0] t;
    t = neg ? ({1'b0, flo} - {1'b0, fq[19:0]}) : ({1'b0, flo} + {1'b0, fq[19:0]});
    fval = (t[19:0] == 20'd0) ? 20'd1 : t[19:0];
  end

  always_comb begin
    unique case (st)
      S_EXEC:               div_go_next = n_need_div;
      S_DIV_FLO, S_DIV_DLY: div_go_next = drsp.done;
      S_DIV_MUL:            div_go_next = (didx == 16'd0);
      default:              div_go_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cfg.backlash_steps <= 16'd320; cfg.accel_steps <= 16'd500;
      cfg.min_delay_us <= 16'd1200; cfg.max_delay_us <= 16'd2400;
      cfg.dir_settle_us <= 16'd50000; cfg.hold_slow <= 1'b0;
      pulse_phase <= PH_BG; motion_state <= MS_IDLE; home_st <= HS_UNHOMED;
      cur_dir <= 2'd2; pend_dir <= 2'd2; rem_steps <= '0; pend_steps <= '0;
      act_ver <= '0; pend_ver <= '0; ramp_pos <= 16'd1; next_dly <= '0;
      backlash_left <= '0; idle_us <= '0; en_flag <= 1'b0; fault_flag <= 1'b0;
      step_lvl <= 1'b0; dir_lvl <= 1'b0; dir_target <= 1'b0; period <= '0;
      p_start <= 1'b0; p_stop <= 1'b0; p_back <= 1'b0; p_pos <= 1'b0;
      div_go <= 1'b0; div_num <= '0; div_den <= '0; didx <= '0; c <= '0;
    end else begin
      div_go <= div_go_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BACKLASH: cfg.backlash_steps <= cfg_data;
          REG_ACCEL:    cfg.accel_steps <= cfg_data;
          REG_MIN_DLY:  cfg.min_delay_us <= cfg_data;
          REG_MAX_DLY:  cfg.max_delay_us <= cfg_data;
          REG_DIR_DLY:  cfg.dir_settle_us <= cfg_data;
          REG_FULL_CAL: cfg.hold_slow <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (st)
        S_IDLE: if (cmd.valid) begin c <= cmd.data; st <= S_EXEC; end
        S_EXEC: begin
          pulse_phase <= n_ph; motion_state <= n_ms; home_st <= n_hs;
          cur_dir <= n_cur; pend_dir <= n_pdir; rem_steps <= n_rem;
          pend_steps <= n_pst; act_ver <= n_av; pend_ver <= n_pv;
          ramp_pos <= n_ramp; next_dly <= n_nd; backlash_left <= n_bl;
          period <= n_per; idle_us <= n_idle; en_flag <= n_en;
          fault_flag <= n_fault; step_lvl <= n_step; dir_lvl <= n_dirl;
          dir_target <= n_dt;
          p_start <= n_ps; p_stop <= n_pp; p_back <= n_pb; p_pos <= n_pr;
          if (n_need_div) begin
            didx <= n_didx;
            div_num <= {16'd0, ONE_MILLION};
            div_den <= {20'd0, maxd};
            st <= S_DIV_FLO;
          end else begin
            st <= S_DONE;
          end
        end
        S_DIV_FLO: if (drsp.done) begin
          flo <= drsp.quotient[19:0];
          div_num <= {16'd0, ONE_MILLION};
          div_den <= {20'd0, mind};
          st <= S_DIV_FHI;
        end
        S_DIV_FHI: if (drsp.done) begin
          fhi <= drsp.quotient[19:0];
          prod <= '0;
          st <= S_DIV_MUL;
        end
        S_DIV_MUL: begin
          if (didx != 16'd0) begin
            prod <= {20'd0, didx} * {16'd0, fdiff};
            didx <= '0;
          end else begin
            div_num <= prod;
            div_den <= {20'd0, acc};
            st <= S_DIV_DLY;
          end
        end
        S_DIV_DLY: if (drsp.done) begin
          div_num <= {16'd0, ONE_MILLION};
          div_den <= {16'd0, fval};
          st <= S_DONE;
          didx <= 16'hFFFF;
        end
        S_DONE: begin
          if (didx == 16'hFFFF) begin
            if (drsp.done) begin
              next_dly <= (drsp.quotient > 36'd65535) ? 16'hFFFF : drsp.quotient[15:0];
              didx <= '0;
            end
          end else if (res.ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    r.step_pin = step_lvl; r.dir_pin = dir_lvl; r.driver_enable = en_flag;
    r.timer_period = period; r.homed = (home_st == HS_HOMED);
    r.fault = fault_flag; r.motion_started = p_start; r.motion_stopped = p_stop;
    r.backoff_started = p_back; r.position_reset = p_pos;
    r.steps_left = 16'(rem_steps);
  end

`ifndef SYNTHESIS
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(fault_flag) |-> fault_flag) else $error("fault cleared");
  a_no_pulse_on_fault: assert property (@(posedge clk) disable iff (rst)
    res.valid && fault_flag |-> !(p_start || p_stop || p_back || p_pos))
    else $error("pulse with fault");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && res.valid)) else $error("ready while result pending");
`endif
endmodule
`default_nettype wire
